### sv/fwra_pkg.sv
`default_nettype none

package fwra_pkg;

   localparam int VALUE_W      = 64;
   localparam int DIGIT_W      = 4;
   localparam int NIBBLE_COUNT = VALUE_W / DIGIT_W;
   localparam int NIBBLE_CNT_W = $clog2(NIBBLE_COUNT);
   localparam int CHAR_W       = 7;
   localparam int CFG_W        = 5;

   localparam logic [CFG_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [CFG_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [CFG_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [CFG_W-1:0] COUNT_RESET = 5'd6;

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

   // one nibble step moving down the cell row
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic               least_first;
      logic [DIGIT_W-1:0] carry;
   } link_type;

   function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + dx;
      end else begin
         return CHAR_LOWER_A + dx - 7'd10;
      end
   endfunction

endpackage

`default_nettype wire

### sv/fwra_cell.sv
`default_nettype none

module fwra_cell
   import fwra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [CFG_W-1:0]   radix_eff,
   input  wire link_type           link_in,
   output link_type                link_out,
   output logic      [DIGIT_W-1:0] digit_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] snap_ff;
   link_type           out_ff;

   logic [CFG_W-1:0]   rem;
   logic [DIGIT_W-1:0] quot;

   // digit = (digit*16 + carry) mod r, carry out = quotient; one bit per step
   always_comb begin
      rem  = link_in.first ? '0 : {1'b0, digit_ff};
      quot = '0;
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         rem = {rem[DIGIT_W-1:0], link_in.carry[i]};
         if (rem >= radix_eff) begin
            rem     = rem - radix_eff;
            quot[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (advance) begin
         out_ff.valid       <= link_in.valid;
         out_ff.first       <= link_in.first;
         out_ff.last        <= link_in.last;
         out_ff.least_first <= link_in.least_first;
         out_ff.carry       <= quot;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && link_in.valid) begin
         digit_ff <= rem[DIGIT_W-1:0];
         if (link_in.last) begin
            snap_ff <= rem[DIGIT_W-1:0];
         end
      end
   end

   assign link_out  = out_ff;
   assign digit_out = snap_ff;

endmodule

`default_nettype wire

### sv/fwra_emit.sv
`default_nettype none

module fwra_emit
   import fwra_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [CFG_W-1:0]   count_eff,
   input  wire link_type           chain_out,
   input  wire logic [DIGIT_W-1:0] snap_digits [MAX_DIGITS],
   output logic                    advance,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [CHAR_W-1:0]  rsp_digit_char,
   output logic                    rsp_last_char,
   output logic                    rsp_out_of_range
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [DIGIT_W-1:0] row_ff [MAX_DIGITS];
   logic               lsf_ff;
   logic               ovf_ff;
   logic               ovf_acc_ff;
   logic               pend_ff;
   logic [CFG_W-1:0]   idx_ff;
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_last_ff;
   logic               rsp_oor_ff;

   logic               out_take;
   logic               emit;
   logic               load_last;
   logic               row_free;
   logic               row_load;
   logic [CFG_W-1:0]   pos_full;
   logic [IDX_W-1:0]   pos;
   logic               high_digit;
   logic               ovf_in;
   logic               acc_base;

   always_comb begin
      high_digit = 1'b0;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if ((CFG_W'(k) >= count_eff) && (snap_digits[k] != '0)) begin
            high_digit = 1'b1;
         end
      end
   end

   assign acc_base  = chain_out.first ? 1'b0 : ovf_acc_ff;
   assign ovf_in    = acc_base || (chain_out.carry != '0) || high_digit;

   assign out_take  = !rsp_valid_ff || !rsp_stall;
   assign emit      = pend_ff && out_take;
   assign load_last = ovf_ff || (idx_ff == (count_eff - 5'd1));
   assign row_free  = !pend_ff || (emit && load_last);
   assign row_load  = chain_out.valid && chain_out.last && row_free;
   assign advance   = !(chain_out.valid && chain_out.last) || row_free;

   assign pos_full  = lsf_ff ? idx_ff : (count_eff - 5'd1 - idx_ff);
   assign pos       = pos_full[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ovf_acc_ff   <= 1'b0;
      end else begin
         if (advance && chain_out.valid) begin
            ovf_acc_ff <= acc_base || (chain_out.carry != '0);
         end
         if (out_take) begin
            rsp_valid_ff <= pend_ff;
         end
         if (row_load) begin
            pend_ff <= 1'b1;
         end else if (emit && load_last) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_ff <= ovf_ff ? CHAR_NONE : glyph(row_ff[pos]);
         rsp_last_ff <= load_last;
         rsp_oor_ff  <= ovf_ff;
      end
      if (row_load) begin
         row_ff <= snap_digits;
         idx_ff <= '0;
         lsf_ff <= chain_out.least_first;
         ovf_ff <= ovf_in;
      end else if (emit) begin
         idx_ff <= idx_ff + 5'd1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_char   = rsp_char_ff;
   assign rsp_last_char    = rsp_last_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_oor_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_oor_ff |-> rsp_last_ff && (rsp_char_ff == CHAR_NONE))
      else $error("out-of-range word not a lone zero last char");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> pend_ff)
      else $error("non-last char shown with no chars left");

   a_load_pend: assert property (@(posedge clock) disable iff (reset)
      row_load |=> pend_ff)
      else $error("row loaded but emitter not busy");

endmodule

`default_nettype wire

### sv/fixed_width_radix_to_ascii_core.sv
// Fixed-width radix-to-ASCII converter.
// req channel: one word per value (req_value, req_least_first), valid/stall.
// rsp channel: one word per character (rsp_digit_char, rsp_last_char,
// rsp_out_of_range). A value converts to exactly digit_count characters,
// zero padded, MS digit first unless req_least_first is set; rsp_last_char
// marks the final one. A value at or above radix^digit_count (exact bound)
// yields a single word: char 0, last 1, out_of_range 1.
// csr port: APB-style, radix at 0x0, digit_count at 0x4, both 5 bits.
// The feeder pushes the 64-bit value into the cell row a nibble per cycle
// while advance is high, and takes the next value as it sends the last
// nibble. Each cell is one base-r digit and folds in 4 bits per advance;
// cells are skewed by a register, so a new value starts while the previous
// one is still rippling up the row. rsp is registered. When rsp stalls,
// chars back up into the row buffer; once a finished row cannot be parked
// there, the cell row and the feeder freeze and a busy feeder keeps
// req_stall high. Reset empties the pipe and sets radix 10, digit_count 6;
// out-of-range configs are clamped (radix 2..16, count 1..MAX_DIGITS).
// Config may only be written while the block is idle.
`default_nettype none

module fixed_width_radix_to_ascii_core
   import fwra_pkg::*;
#(
   parameter int MAX_DIGITS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic               req_least_first,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [CHAR_W-1:0]  rsp_digit_char,
   output logic                    rsp_last_char,
   output logic                    rsp_out_of_range,

   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic      [31:0]        csr_prdata,
   output logic                    csr_pready
);

   localparam logic REG_RADIX = 1'b0;
   localparam logic REG_COUNT = 1'b1;
   localparam logic [NIBBLE_CNT_W-1:0] NIBBLE_LAST = NIBBLE_CNT_W'(NIBBLE_COUNT - 1);

   // ---- configuration registers ----
   logic [CFG_W-1:0] radix_ff;
   logic [CFG_W-1:0] count_ff;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_RADIX: radix_ff <= csr_pwdata[CFG_W-1:0];
            REG_COUNT: count_ff <= csr_pwdata[CFG_W-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RADIX: csr_prdata = {{(32-CFG_W){1'b0}}, radix_ff};
         REG_COUNT: csr_prdata = {{(32-CFG_W){1'b0}}, count_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // clamped settings used by the datapath
   logic [CFG_W-1:0] radix_eff;
   logic [CFG_W-1:0] count_eff;

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
      if (count_ff == '0) begin
         count_eff = 5'd1;
      end else if (count_ff > CFG_W'(MAX_DIGITS)) begin
         count_eff = CFG_W'(MAX_DIGITS);
      end else begin
         count_eff = count_ff;
      end
   end

   // ---- feeder: value enters MS nibble first, one nibble per cycle while advance is high ----
   logic [VALUE_W-1:0]      feed_value_ff;
   logic [NIBBLE_CNT_W-1:0] feed_cnt_ff;
   logic                    feed_busy_ff;
   logic                    feed_lsf_ff;
   logic                    advance;
   logic                    req_accept;
   logic                    feed_last;

   assign feed_last  = (feed_cnt_ff == NIBBLE_LAST);
   assign req_stall  = feed_busy_ff && !(advance && feed_last);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_busy_ff <= 1'b0;
         feed_cnt_ff  <= '0;
      end else if (req_accept) begin
         feed_busy_ff <= 1'b1;
         feed_cnt_ff  <= '0;
      end else if (advance && feed_busy_ff) begin
         feed_cnt_ff <= feed_cnt_ff + NIBBLE_CNT_W'(1);
         if (feed_last) begin
            feed_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         feed_value_ff <= req_value;
         feed_lsf_ff   <= req_least_first;
      end else if (advance && feed_busy_ff) begin
         feed_value_ff <= {feed_value_ff[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   // ---- cell row: cell k holds the digit of weight radix^k ----
   link_type           links [MAX_DIGITS+1];
   logic [DIGIT_W-1:0] snap_digits [MAX_DIGITS];

   always_comb begin
      links[0].valid       = feed_busy_ff;
      links[0].first       = (feed_cnt_ff == '0);
      links[0].last        = feed_last;
      links[0].least_first = feed_lsf_ff;
      links[0].carry       = feed_value_ff[VALUE_W-1 -: DIGIT_W];
   end

   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
      fwra_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .radix_eff (radix_eff),
         .link_in   (links[k]),
         .link_out  (links[k+1]),
         .digit_out (snap_digits[k])
      );
   end

   // ---- row buffer and character output ----
   fwra_emit #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .count_eff        (count_eff),
      .chain_out        (links[MAX_DIGITS]),
      .snap_digits      (snap_digits),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_char    (rsp_last_char),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire
